FILE: rtl/rrc_pkg.sv
// Package with the shared constants and cell word types of the raw-to-Celsius unit.
`timescale 1ns / 1ps

package rrc_pkg;

	// Widths of the datapath words.
	localparam int NUM_W   = 128;
	localparam int DEN_W   = 62;
	localparam int OFS_W   = 64;
	localparam int Y_W     = 25;
	localparam int Y2_W    = 50;
	localparam int Y3_W    = 75;
	localparam int INNER_W = 100;

	// Fixed-point constants of the conversion.
	localparam logic signed [41:0] GAIN_UNIT      = 42'sd1638400;
	localparam logic signed [24:0] GAIN_SLOPE_Q14 = 25'sd8344371;
	localparam logic signed [17:0] CAM_REF_CK     = 18'sd32000;
	localparam logic signed [17:0] OFFSET_BIAS_CK = 18'sd200;
	localparam logic [23:0]        K_Q32          = 24'd9716679;
	localparam logic [17:0]        RAW_SCALE      = 18'd250000;
	localparam int                 RAW_SHIFT_BASE = 55;
	localparam logic signed [25:0] KELVIN_ZERO_CK = 26'sd27315;
	localparam logic signed [25:0] OUT_MAX_WIDE   = 26'sd8388607;
	localparam logic [23:0]        OUT_MAX        = 24'd8388607;

	// Word handed from one divider cell to the next.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] nq;
		logic [DEN_W-1:0] den;
		logic [OFS_W-1:0] offset;
		logic             neg;
		logic             gzero;
	} div_word_t;

	// Word handed from one root cell to the next.
	typedef struct packed {
		logic [Y_W-1:0]     y;
		logic [Y2_W-1:0]    y2;
		logic [Y3_W-1:0]    y3;
		logic [INNER_W-1:0] y4;
		logic [INNER_W-1:0] inner;
		logic               invalid;
		logic               sat;
	} root_word_t;

endpackage

FILE: rtl/rrc_div_cell.sv
// One restoring division cell: produces one quotient bit per item.
`timescale 1ns / 1ps

module rrc_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  rrc_pkg::div_word_t  word_in,
	output logic                valid_q,
	output rrc_pkg::div_word_t  word_q
);

	logic [rrc_pkg::DEN_W:0] trial;
	logic                    fits;
	rrc_pkg::div_word_t      word_next;

	// Shift the next numerator bit into the remainder and try the subtract.
	always_comb begin
		trial = {word_in.rem, word_in.nq[rrc_pkg::NUM_W-1]};
		fits = trial >= {1'b0, word_in.den};
		word_next = word_in;
		if (fits) begin
			word_next.rem = rrc_pkg::DEN_W'(trial - {1'b0, word_in.den});
		end else begin
			word_next.rem = trial[rrc_pkg::DEN_W-1:0];
		end
		word_next.nq = {word_in.nq[rrc_pkg::NUM_W-2:0], fits};
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload of the cell.
	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_next;
		end
	end

endmodule

FILE: rtl/rrc_root_cell.sv
// One fourth-root cell: decides one bit of the root from running powers.
`timescale 1ns / 1ps

module rrc_root_cell #(
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  rrc_pkg::root_word_t word_in,
	output logic                valid_q,
	output rrc_pkg::root_word_t word_q
);

	localparam int IW = rrc_pkg::INNER_W;

	logic [IW-1:0]       yw;
	logic [IW-1:0]       y2w;
	logic [IW-1:0]       y3w;
	logic [IW-1:0]       one;
	logic [IW-1:0]       c2;
	logic [IW-1:0]       c3;
	logic [IW-1:0]       c4;
	rrc_pkg::root_word_t word_next;

	// Powers of the candidate y + 2^BIT from the powers of y, by shifts and adds.
	always_comb begin
		yw  = IW'(word_in.y);
		y2w = IW'(word_in.y2);
		y3w = IW'(word_in.y3);
		one = IW'(1);
		c2 = y2w + (yw << (BIT + 1)) + (one << (2 * BIT));
		c3 = y3w + (y2w << BIT) + (y2w << (BIT + 1)) + (yw << (2 * BIT))
			+ (yw << (2 * BIT + 1)) + (one << (3 * BIT));
		c4 = word_in.y4 + (y3w << (BIT + 2)) + (y2w << (2 * BIT + 1))
			+ (y2w << (2 * BIT + 2)) + (yw << (3 * BIT + 2)) + (one << (4 * BIT));
		word_next = word_in;
		if (c4 <= word_in.inner) begin
			word_next.y  = word_in.y | (rrc_pkg::Y_W'(1) << BIT);
			word_next.y2 = c2[rrc_pkg::Y2_W-1:0];
			word_next.y3 = c3[rrc_pkg::Y3_W-1:0];
			word_next.y4 = c4;
		end
	end

	// Valid bit of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// Payload of the cell.
	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_next;
		end
	end

endmodule

FILE: rtl/radiometric_raw_to_celsius_unit.sv
// Top level: radiometric raw count and camera temperature to scene degrees Celsius.
//
//   channel  | handshake                    | fields
//   ---------+------------------------------+------------------------------------
//   sample   | sample_valid / sample_stall  | raw_sample, camera_temp
//   result   | result_valid / result_stall  | temp_celsius, invalid, saturated
//
// One item is taken in every cycle while sample_stall is low. There are 158 register
// stages: three setup stages, 128 division cells, one combine stage, 25 root cells and
// the output register.
// Reset clears only the valid bits of the stages.
// A stalled result parks in a skid register; while it is full the whole chain
// holds and sample_stall is high.
`timescale 1ns / 1ps

module radiometric_raw_to_celsius_unit #(
	parameter int RAW_FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [23:0] raw_sample,
	input  logic [15:0]        camera_temp,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [23:0] temp_celsius,
	output logic               invalid,
	output logic               saturated
);

	localparam int NUM_W     = rrc_pkg::NUM_W;
	localparam int Y_W       = rrc_pkg::Y_W;
	localparam int RAW_SHIFT = rrc_pkg::RAW_SHIFT_BASE - RAW_FRACTION_BITS;

	logic en;

	// Setup stage 1 signals.
	logic               v_s1;
	logic [15:0]        c_s1;
	logic               rneg_s1;
	logic signed [41:0] g_s1;
	logic [15:0]        oabs_s1;
	logic [39:0]        rc_s1;
	logic [23:0]        rabs;
	logic signed [17:0] cdiff;
	logic signed [17:0] odiff;
	logic signed [42:0] gprod;

	// Setup stage 2 signals.
	logic        v_s2;
	logic [38:0] gabs_s2;
	logic        gzero_s2;
	logic        neg_s2;
	logic [31:0] osq_s2;
	logic [55:0] rcc_s2;

	// Setup stage 3 signals.
	logic                      v_s3;
	logic [rrc_pkg::DEN_W-1:0] den_s3;
	logic [rrc_pkg::OFS_W-1:0] offset_s3;
	logic [NUM_W-1:0]          num_s3;
	logic                      gzero_s3;
	logic                      neg_s3;
	logic [62:0]               den_full;
	logic [73:0]               scaled;

	// Cell chains.
	logic                div_v [0:NUM_W];
	rrc_pkg::div_word_t  div_w [0:NUM_W];
	logic                root_v [0:Y_W];
	rrc_pkg::root_word_t root_w [0:Y_W];

	// Combine stage signals.
	logic                v_s4;
	rrc_pkg::root_word_t comb_s4;
	logic [NUM_W:0]      sum;
	logic                too_big;

	// Output signals.
	logic signed [25:0] res;
	logic signed [23:0] fmt_temp;
	logic               fmt_invalid;
	logic               fmt_sat;
	logic               main_v_q;
	logic               skid_v_q;
	logic signed [23:0] main_temp_q;
	logic               main_inv_q;
	logic               main_sat_q;
	logic signed [23:0] skid_temp_q;
	logic               skid_inv_q;
	logic               skid_sat_q;
	logic               main_free;
	logic               load_from_skid;
	logic               load_from_pipe;
	logic               load_skid;

	assign en = !skid_v_q;
	assign sample_stall = skid_v_q;

	// Stage 1: gain, offset base and first product of the raw term.
	always_comb begin
		rabs  = raw_sample[23] ? (~raw_sample + 24'd1) : raw_sample;
		cdiff = $signed({2'b00, camera_temp}) - rrc_pkg::CAM_REF_CK;
		odiff = $signed({2'b00, camera_temp}) - rrc_pkg::OFFSET_BIAS_CK;
		gprod = cdiff * rrc_pkg::GAIN_SLOPE_Q14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= camera_temp;
			rneg_s1 <= raw_sample[23];
			g_s1    <= gprod[41:0] + rrc_pkg::GAIN_UNIT;
			oabs_s1 <= odiff[17] ? 16'(-odiff) : odiff[15:0];
			rc_s1   <= 40'(rabs) * 40'(camera_temp);
		end
	end

	// Stage 2: gain magnitude and sign, offset square, second raw product.
	always_ff @(posedge clk) begin
		if (en) begin
			gabs_s2  <= g_s1[41] ? 39'(-g_s1) : g_s1[38:0];
			gzero_s2 <= g_s1 == 42'sd0;
			neg_s2   <= rneg_s1 ^ g_s1[41];
			osq_s2   <= 32'(oabs_s1) * 32'(oabs_s1);
			rcc_s2   <= 56'(rc_s1) * 56'(c_s1);
		end
	end

	// Stage 3: divisor, fourth-power offset and scaled numerator.
	always_comb begin
		den_full = 63'(gabs_s2) * 63'(rrc_pkg::K_Q32);
		scaled   = 74'(rcc_s2) * 74'(rrc_pkg::RAW_SCALE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3    <= den_full[rrc_pkg::DEN_W-1:0];
			offset_s3 <= 64'(osq_s2) * 64'(osq_s2);
			num_s3    <= NUM_W'(scaled) << RAW_SHIFT;
			gzero_s3  <= gzero_s2;
			neg_s3    <= neg_s2;
		end
	end

	// Division chain, one quotient bit per cell.
	assign div_v[0] = v_s3;
	assign div_w[0] = '{rem: '0, nq: num_s3, den: den_s3, offset: offset_s3,
		neg: neg_s3, gzero: gzero_s3};

	for (genvar i = 0; i < NUM_W; i++) begin : g_div
		rrc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (div_v[i]),
			.word_in  (div_w[i]),
			.valid_q  (div_v[i+1]),
			.word_q   (div_w[i+1])
		);
	end

	// Stage 4: join the raw term with the offset and check the range.
	always_comb begin
		too_big = div_w[NUM_W].nq > NUM_W'(div_w[NUM_W].offset);
		if (div_w[NUM_W].neg) begin
			sum = (NUM_W+1)'(div_w[NUM_W].offset) - (NUM_W+1)'(div_w[NUM_W].nq);
		end else begin
			sum = (NUM_W+1)'(div_w[NUM_W].offset) + (NUM_W+1)'(div_w[NUM_W].nq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_v[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			comb_s4 <= '{y: '0, y2: '0, y3: '0, y4: '0,
				inner: sum[rrc_pkg::INNER_W-1:0],
				invalid: div_w[NUM_W].gzero | (div_w[NUM_W].neg & too_big),
				sat: |sum[NUM_W:rrc_pkg::INNER_W]};
		end
	end

	// Fourth-root chain, most significant bit first.
	assign root_v[0] = v_s4;
	assign root_w[0] = comb_s4;

	for (genvar j = 0; j < Y_W; j++) begin : g_root
		rrc_root_cell #(
			.BIT (Y_W - 1 - j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (root_v[j]),
			.word_in  (root_w[j]),
			.valid_q  (root_v[j+1]),
			.word_q   (root_w[j+1])
		);
	end

	// Result formatting: kelvin to Celsius, flags and clipping.
	always_comb begin
		res = $signed({1'b0, root_w[Y_W].y}) - rrc_pkg::KELVIN_ZERO_CK;
		fmt_temp = '0;
		fmt_invalid = 1'b0;
		fmt_sat = 1'b0;
		priority if (root_w[Y_W].invalid) begin
			fmt_invalid = 1'b1;
		end else if (root_w[Y_W].sat || res > rrc_pkg::OUT_MAX_WIDE) begin
			fmt_temp = rrc_pkg::OUT_MAX;
			fmt_sat = 1'b1;
		end else begin
			fmt_temp = res[23:0];
		end
	end

	// Output register and skid register steering.
	always_comb begin
		main_free      = !main_v_q || !result_stall;
		load_from_skid = skid_v_q && main_free;
		load_from_pipe = !skid_v_q && root_v[Y_W] && main_free;
		load_skid      = !skid_v_q && root_v[Y_W] && !main_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_from_skid || load_from_pipe) begin
				main_v_q <= 1'b1;
			end else if (main_free) begin
				main_v_q <= 1'b0;
			end
			if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			main_temp_q <= skid_temp_q;
			main_inv_q  <= skid_inv_q;
			main_sat_q  <= skid_sat_q;
		end else if (load_from_pipe) begin
			main_temp_q <= fmt_temp;
			main_inv_q  <= fmt_invalid;
			main_sat_q  <= fmt_sat;
		end
		if (load_skid) begin
			skid_temp_q <= fmt_temp;
			skid_inv_q  <= fmt_invalid;
			skid_sat_q  <= fmt_sat;
		end
	end

	assign result_valid = main_v_q;
	assign temp_celsius = main_temp_q;
	assign invalid      = main_inv_q;
	assign saturated    = main_sat_q;

endmodule
